/* rtl/echo_pulse_distance_meter_macros.svh */
// Assertion macros used by the echo pulse distance meter RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ECHO_PULSE_DISTANCE_METER_MACROS_SVH
`define ECHO_PULSE_DISTANCE_METER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define EPDM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define EPDM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/epdm_pkg.sv */
// Package for the echo pulse distance meter: codes, payload types, divider constants.
// No dependencies.
`default_nettype none

package epdm_pkg;

   // function codes of a request transaction
   localparam logic [1:0] FN_ARM   = 2'd0;
   localparam logic [1:0] FN_EDGE  = 2'd1;
   localparam logic [1:0] FN_CLEAR = 2'd2;

   // status codes of a response transaction
   localparam logic [2:0] ST_IGNORED = 3'd0;
   localparam logic [2:0] ST_ARMED   = 3'd1;
   localparam logic [2:0] ST_RISE    = 3'd2;
   localparam logic [2:0] ST_DONE    = 3'd3;
   localparam logic [2:0] ST_CLEARED = 3'd4;

   localparam int STAMP_W = 32;
   localparam int DIST_W  = 16;

   // width / 58 == (width >> 1) / 29 == ((width >> 1) * ceil(2^36 / 29)) >> 36,
   // exact for every 31-bit dividend
   localparam logic [31:0] DIV58_MAGIC = 32'd2369637129;
   localparam int          DIV58_SHIFT = 36;

   typedef struct packed {
      logic [1:0]         func;
      logic [1:0]         channel;
      logic [STAMP_W-1:0] capture_value;
   } req_type;

   // state-stage result handed to the divide stage
   typedef struct packed {
      logic [1:0]         channel_out;
      logic [2:0]         status;
      logic [STAMP_W-1:0] pulse_width;
      logic [STAMP_W-1:0] width_sel;
      logic               ready_res;
   } mid_type;

   typedef struct packed {
      logic [1:0]         channel_out;
      logic [2:0]         status;
      logic [STAMP_W-1:0] pulse_width;
      logic [DIST_W-1:0]  distance_cm;
      logic               ready_res;
   } rsp_type;

endpackage

`default_nettype wire

/* rtl/epdm_if.sv */
// Valid/ready channel interfaces for request and response transactions.
// Depends on epdm_pkg.
`default_nettype none

interface epdm_req_if import epdm_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [1:0]         func;
   logic [1:0]         channel;
   logic [STAMP_W-1:0] capture_value;

   modport source (output valid, output func, output channel, output capture_value,
                   input ready);
   modport sink   (input valid, input func, input channel, input capture_value,
                   output ready);
endinterface

interface epdm_rsp_if import epdm_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [1:0]         channel_out;
   logic [2:0]         status;
   logic [STAMP_W-1:0] pulse_width;
   logic [DIST_W-1:0]  distance_cm;
   logic               ready_res;

   modport source (output valid, output channel_out, output status, output pulse_width,
                   output distance_cm, output ready_res, input ready);
   modport sink   (input valid, input channel_out, input status, input pulse_width,
                   input distance_cm, input ready_res, output ready);
endinterface

`default_nettype wire

/* rtl/epdm_chan.sv */
// Per-channel echo state (phase, start stamp, last width, ready flag) and its update.
// Depends on epdm_pkg and echo_pulse_distance_meter_macros.svh.
`default_nettype none
`include "echo_pulse_distance_meter_macros.svh"

module epdm_chan import epdm_pkg::*; #(
   parameter int NUM_CHANNELS = 3,
   parameter int TIMER_BITS   = 32
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   input  wire req_type in_data,
   output      logic    in_ready,
   output      logic    mid_valid,
   output      mid_type mid_data,
   input  wire logic    mid_ready
);

   localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_RISE = 2'd1,
      PH_FALL = 2'd2
   } phase_type;

   phase_type             phase_ff [NUM_CHANNELS];
   logic [TIMER_BITS-1:0] start_ff [NUM_CHANNELS];
   logic [TIMER_BITS-1:0] width_ff [NUM_CHANNELS];
   logic                  rdy_ff   [NUM_CHANNELS];

   logic                  mid_valid_ff;
   mid_type               mid_ff;
   mid_type               mid_in;

   logic [CH_W-1:0]       idx;
   logic                  ch_ok;
   logic                  take;
   logic [TIMER_BITS-1:0] stamp;
   logic [TIMER_BITS-1:0] diff;
   phase_type             cur_phase;
   phase_type             phase_in;
   logic [TIMER_BITS-1:0] start_in;
   logic [TIMER_BITS-1:0] width_in;
   logic                  rdy_in;
   logic [2:0]            status;
   logic                  done;

   assign in_ready  = !mid_valid_ff || mid_ready;
   assign take      = in_valid && in_ready;
   assign mid_valid = mid_valid_ff;
   assign mid_data  = mid_ff;

   // decode the transaction against the addressed channel
   always_comb begin
      idx       = CH_W'(in_data.channel);
      ch_ok     = int'(in_data.channel) < NUM_CHANNELS;
      stamp     = in_data.capture_value[TIMER_BITS-1:0];
      cur_phase = phase_ff[idx];
      diff      = stamp - start_ff[idx];
      phase_in  = cur_phase;
      start_in  = start_ff[idx];
      width_in  = width_ff[idx];
      rdy_in    = rdy_ff[idx];
      status    = ST_IGNORED;
      done      = 1'b0;
      case (in_data.func)
         FN_ARM: begin
            phase_in = PH_RISE;
            status   = ST_ARMED;
         end
         FN_EDGE: begin
            case (cur_phase)
               PH_RISE: begin
                  start_in = stamp;
                  phase_in = PH_FALL;
                  status   = ST_RISE;
               end
               PH_FALL: begin
                  width_in = diff;
                  rdy_in   = 1'b1;
                  phase_in = PH_IDLE;
                  status   = ST_DONE;
                  done     = 1'b1;
               end
               default: begin
                  status = ST_IGNORED;
               end
            endcase
         end
         FN_CLEAR: begin
            rdy_in = 1'b0;
            status = ST_CLEARED;
         end
         default: begin
            status = ST_IGNORED;
         end
      endcase

      mid_in.channel_out = in_data.channel;
      if (ch_ok) begin
         mid_in.status      = status;
         mid_in.pulse_width = done ? STAMP_W'(diff) : '0;
         mid_in.width_sel   = STAMP_W'(width_in);
         mid_in.ready_res   = rdy_in;
      end else begin
         mid_in.status      = ST_IGNORED;
         mid_in.pulse_width = '0;
         mid_in.width_sel   = '0;
         mid_in.ready_res   = 1'b0;
      end
   end

   // channel state, written once per accepted transaction to a valid channel
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            phase_ff[i] <= PH_IDLE;
            start_ff[i] <= '0;
            width_ff[i] <= '0;
            rdy_ff[i]   <= 1'b0;
         end
      end else if (take && ch_ok) begin
         phase_ff[idx] <= phase_in;
         start_ff[idx] <= start_in;
         width_ff[idx] <= width_in;
         rdy_ff[idx]   <= rdy_in;
      end
   end

   // stage register towards the divide stage
   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
      end else if (in_ready) begin
         mid_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         mid_ff <= mid_in;
      end
   end

   // a completed measurement always leaves the ready flag set
   `EPDM_ASSERT_NOW(a_done_ready, clock, reset, mid_valid_ff && (mid_ff.status == ST_DONE), mid_ff.ready_res, "done without ready flag")
   // only a completed measurement reports a pulse width
   `EPDM_ASSERT_NOW(a_width_only_done, clock, reset, mid_valid_ff && (mid_ff.status != ST_DONE), mid_ff.pulse_width == '0, "pulse width outside done")
   // an accepted arm leaves the stage with the armed status
   `EPDM_ASSERT_NEXT(a_arm_status, clock, reset, take && ch_ok && (in_data.func == FN_ARM), mid_ff.status == ST_ARMED, "arm not reported")

endmodule

`default_nettype wire

/* rtl/epdm_div.sv */
// Divide stage: stored width / 58 by reciprocal multiply, plus the response register.
// Depends on epdm_pkg.
`default_nettype none

module epdm_div import epdm_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   input  wire mid_type in_data,
   output      logic    in_ready,
   output      logic    out_valid,
   output      rsp_type out_data,
   input  wire logic    out_ready
);

   logic          out_valid_ff;
   rsp_type       out_ff;
   rsp_type       out_in;
   logic [62:0]   product;

   assign in_ready  = !out_valid_ff || out_ready;
   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

   // (width >> 1) * ceil(2^36 / 29), quotient in bits above the shift
   always_comb begin
      product            = 63'(in_data.width_sel[STAMP_W-1:1]) * 63'(DIV58_MAGIC);
      out_in.channel_out = in_data.channel_out;
      out_in.status      = in_data.status;
      out_in.pulse_width = in_data.pulse_width;
      out_in.distance_cm = product[DIV58_SHIFT +: DIST_W];
      out_in.ready_res   = in_data.ready_res;
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (in_ready) begin
         out_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         out_ff <= out_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/echo_pulse_distance_meter.sv */
// Echo pulse distance meter: up to four echo timer channels behind one request channel.
// Channels: req_if (sink) carries func, channel and a timer stamp; rsp_if (source)
// returns one response transaction per request, in request order.
// func arm puts a channel into waiting for the rising edge; the next edge capture
// stores the start stamp, the one after it gives the pulse width (modulo 2^TIMER_BITS),
// sets the ready flag and a distance of width / 58 cm (low 16 bits). func clear
// drops the ready flag. Requests for an unknown channel or an unused code are
// answered with status ignored and change nothing.
// Path: a request passes the input register, the channel stage register and the
// response register, in that order, before its response is valid.
// Throughput: one transaction per cycle while the response side does not stall; the channel
// state is read and written in the same cycle, so back-to-back requests to the same channel see each other.
// Reset: all channels idle, stamps, distances and ready flags zero, pipeline empty.
// Stall: a held response stalls the pipeline stage by stage; the request side keeps
// accepting until every stage is full, and nothing is dropped or repeated.
// Depends on epdm_pkg, epdm_if, epdm_chan and epdm_div.
`default_nettype none

module echo_pulse_distance_meter import epdm_pkg::*; #(
   parameter int NUM_CHANNELS = 3,
   parameter int TIMER_BITS   = 32
) (
   input wire logic    clock,
   input wire logic    reset,
   epdm_req_if.sink    req_if,
   epdm_rsp_if.source  rsp_if
);

   logic    in_valid_ff;
   req_type in_ff;
   logic    chan_ready;
   logic    mid_valid;
   mid_type mid_data;
   logic    div_ready;
   logic    out_valid;
   rsp_type out_data;

   assign req_if.ready = !in_valid_ff || chan_ready;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         in_ff.func          <= req_if.func;
         in_ff.channel       <= req_if.channel;
         in_ff.capture_value <= req_if.capture_value;
      end
   end

   epdm_chan #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .TIMER_BITS   (TIMER_BITS)
   ) u_chan (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .in_data   (in_ff),
      .in_ready  (chan_ready),
      .mid_valid (mid_valid),
      .mid_data  (mid_data),
      .mid_ready (div_ready)
   );

   epdm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_data   (mid_data),
      .in_ready  (div_ready),
      .out_valid (out_valid),
      .out_data  (out_data),
      .out_ready (rsp_if.ready)
   );

   // response channel
   assign rsp_if.valid       = out_valid;
   assign rsp_if.channel_out = out_data.channel_out;
   assign rsp_if.status      = out_data.status;
   assign rsp_if.pulse_width = out_data.pulse_width;
   assign rsp_if.distance_cm = out_data.distance_cm;
   assign rsp_if.ready_res   = out_data.ready_res;

endmodule

`default_nettype wire

/* verif/testbench.sv */
// Testbench for echo_pulse_distance_meter: directed and random echo ranging traffic,
// a per-channel ranging predictor and an in-order response scoreboard.
// Depends on epdm_pkg, epdm_if and the echo_pulse_distance_meter RTL.
module testbench;
   import epdm_pkg::*;

   localparam int          NUM_CH       = 3;
   localparam logic [1:0]  FN_UNUSED    = 2'd3;
   localparam logic [31:0] TICKS_PER_CM = 32'd58;
   localparam logic [31:0] DIST_WRAP    = 32'd3801088;   // 58 * 2^16 ticks
   localparam int          IDLE_LIMIT   = 2000;
   localparam int          PHASE_ITEMS  = 382;

   // echo timer channel state as the predictor sees it
   typedef enum logic [1:0] {
      ECHO_IDLE      = 2'd0,
      ECHO_WAIT_RISE = 2'd1,
      ECHO_WAIT_FALL = 2'd2
   } echo_stage_type;

   typedef struct packed {
      echo_stage_type stage;
      logic [31:0]    t_start;
      logic [15:0]    range_cm;
      logic           rdy;
   } chan_state_type;

   typedef chan_state_type [NUM_CH-1:0] bank_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   epdm_req_if req_bus ();
   epdm_rsp_if rsp_bus ();

   echo_pulse_distance_meter dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   req_type     pending_reqs[$];
   rsp_type     expected_rsps[$];
   bank_type    model_bank;    // follows accepted transactions
   bank_type    plan_bank;     // follows generated transactions, steers the stimulus
   int unsigned issued_reqs   = 0;
   int unsigned accepted_reqs = 0;
   int unsigned fail_count    = 0;
   int unsigned idle_cycles   = 0;
   int unsigned send_gap_pct  = 0;
   int unsigned stall_pct     = 0;
   req_type     drive_req;
   req_type     seen_req;
   rsp_type     want;

   // clock, period 12
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ranging predictor: one response per request, state updated in place
   function automatic rsp_type echo_step(input req_type rq, inout bank_type bank);
      rsp_type     rs;
      logic [31:0] w;
      logic [31:0] q;
      rs             = '0;
      rs.channel_out = rq.channel;
      rs.status      = ST_IGNORED;
      if (rq.channel < NUM_CH) begin
         case (rq.func)
            FN_ARM: begin
               bank[rq.channel].stage = ECHO_WAIT_RISE;
               rs.status              = ST_ARMED;
            end
            FN_EDGE: begin
               if (bank[rq.channel].stage == ECHO_WAIT_RISE) begin
                  bank[rq.channel].t_start = rq.capture_value;
                  bank[rq.channel].stage   = ECHO_WAIT_FALL;
                  rs.status                = ST_RISE;
               end else if (bank[rq.channel].stage == ECHO_WAIT_FALL) begin
                  // width wraps with the timer
                  w                         = rq.capture_value - bank[rq.channel].t_start;
                  q                         = w / TICKS_PER_CM;
                  bank[rq.channel].range_cm = q[15:0];
                  bank[rq.channel].rdy      = 1'b1;
                  bank[rq.channel].stage    = ECHO_IDLE;
                  rs.pulse_width            = w;
                  rs.status                 = ST_DONE;
               end
            end
            FN_CLEAR: begin
               bank[rq.channel].rdy = 1'b0;
               rs.status            = ST_CLEARED;
            end
            default: ;
         endcase
         rs.distance_cm = bank[rq.channel].range_cm;
         rs.ready_res   = bank[rq.channel].rdy;
      end
      return rs;
   endfunction

   task automatic add_req(input logic [1:0] fn, input logic [1:0] ch, input logic [31:0] stamp);
      req_type rq;
      rq.func          = fn;
      rq.channel       = ch;
      rq.capture_value = stamp;
      void'(echo_step(rq, plan_bank));
      pending_reqs.push_back(rq);
      issued_reqs++;
   endtask

   // mostly well-formed arm / rise / fall sequences interleaved over channels, plus noise
   task automatic add_random(input int count);
      int unsigned r;
      int unsigned ch;
      logic [31:0] w;
      for (int i = 0; i < count; i++) begin
         r  = $urandom_range(0, 99);
         ch = $urandom_range(0, NUM_CH - 1);
         if (r < 12) begin
            add_req(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), $urandom);
         end else begin
            case (plan_bank[ch].stage)
               ECHO_WAIT_RISE: begin
                  if (r < 16) add_req(FN_ARM, 2'(ch), $urandom);
                  else add_req(FN_EDGE, 2'(ch), $urandom);
               end
               ECHO_WAIT_FALL: begin
                  case ($urandom_range(0, 4))
                     0: w = $urandom_range(0, 2000);
                     1: w = $urandom;
                     2: w = DIST_WRAP * $urandom_range(1, 4) - $urandom_range(0, 58);
                     3: w = DIST_WRAP * $urandom_range(1, 4) + $urandom_range(0, 58);
                     default: w = $urandom_range(116000, 2000000);
                  endcase
                  if (r < 18) add_req(FN_ARM, 2'(ch), $urandom);
                  else if (r < 22) add_req(FN_CLEAR, 2'(ch), $urandom);
                  else add_req(FN_EDGE, 2'(ch), plan_bank[ch].t_start + w);
               end
               default: begin
                  if (r < 30) add_req(FN_CLEAR, 2'(ch), $urandom);
                  else add_req(FN_ARM, 2'(ch), $urandom);
               end
            endcase
         end
      end
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() != 0) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid         <= 1'b0;
         req_bus.func          <= FN_ARM;
         req_bus.channel       <= 2'd0;
         req_bus.capture_value <= '0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
            drive_req = pending_reqs.pop_front();
            req_bus.valid         <= 1'b1;
            req_bus.func          <= drive_req.func;
            req_bus.channel       <= drive_req.channel;
            req_bus.capture_value <= drive_req.capture_value;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // request monitor: predict the response of each accepted transaction
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         seen_req.func          = req_bus.func;
         seen_req.channel       = req_bus.channel;
         seen_req.capture_value = req_bus.capture_value;
         expected_rsps.push_back(echo_step(seen_req, model_bank));
         accepted_reqs++;
      end
   end

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (act_v !== exp_v) begin
         $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   // response sink and scoreboard
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_rsps.size() == 0) begin
               $error("response transaction with no request outstanding");
               fail_count++;
            end else begin
               want = expected_rsps.pop_front();
               check_field("channel_out", 32'(want.channel_out), 32'(rsp_bus.channel_out));
               check_field("status", 32'(want.status), 32'(rsp_bus.status));
               check_field("pulse_width", want.pulse_width, rsp_bus.pulse_width);
               check_field("distance_cm", 32'(want.distance_cm), 32'(rsp_bus.distance_cm));
               check_field("ready_res", 32'(want.ready_res), 32'(rsp_bus.ready_res));
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("[echo_pulse_distance_meter] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      model_bank = '0;
      plan_bank  = '0;

      // directed: ignored cases
      add_req(FN_EDGE, 2'd0, 32'h0000_0000);   // edge on an idle channel
      add_req(FN_CLEAR, 2'd0, 32'hFFFF_FFFF);  // clear while idle
      add_req(FN_ARM, 2'd3, 32'h0000_0000);    // invalid channel
      add_req(FN_EDGE, 2'd3, 32'hFFFF_FFFF);
      add_req(FN_UNUSED, 2'd1, 32'hFFFF_FFFF); // unused function code
      // full-scale width
      add_req(FN_ARM, 2'd0, 32'h0);
      add_req(FN_EDGE, 2'd0, 32'h0000_0000);
      add_req(FN_EDGE, 2'd0, 32'hFFFF_FFFF);
      // timer wrap between edges
      add_req(FN_ARM, 2'd1, 32'h0);
      add_req(FN_EDGE, 2'd1, 32'hFFFF_FFF0);
      add_req(FN_EDGE, 2'd1, 32'h0000_0010);
      // zero width
      add_req(FN_ARM, 2'd2, 32'h0);
      add_req(FN_EDGE, 2'd2, 32'h0000_0005);
      add_req(FN_EDGE, 2'd2, 32'h0000_0005);
      // re-arm while waiting for either edge, then a distance that wraps to zero
      add_req(FN_ARM, 2'd2, 32'h0);
      add_req(FN_ARM, 2'd2, 32'h0);
      add_req(FN_EDGE, 2'd2, 32'd100);
      add_req(FN_ARM, 2'd2, 32'h0);
      add_req(FN_EDGE, 2'd2, 32'd200);
      add_req(FN_EDGE, 2'd2, 32'd200 + DIST_WRAP);
      // clear while ready, and while waiting for the rising edge
      add_req(FN_CLEAR, 2'd1, 32'h0);
      add_req(FN_ARM, 2'd1, 32'h0);
      add_req(FN_CLEAR, 2'd1, 32'h0);

      // random phases: free flow, slow sender, slow receiver, both slightly
      add_random(PHASE_ITEMS);
      wait_drained();
      send_gap_pct <= 82;
      add_random(PHASE_ITEMS);
      wait_drained();
      send_gap_pct <= 0;
      stall_pct    <= 82;
      add_random(PHASE_ITEMS);
      wait_drained();
      send_gap_pct <= 6;
      stall_pct    <= 6;
      add_random(PHASE_ITEMS);

      while (accepted_reqs != issued_reqs || expected_rsps.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("[echo_pulse_distance_meter] OK");
      end else begin
         $display("[echo_pulse_distance_meter] ERROR");
      end
      $finish;
   end

   // reset asserted at the start, then released
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

endmodule
